### rtl/bps_pkg.sv
// Package for the bit permutation step block: widths, reset length, result type
// and the window mask function. Used by all rtl files; depends on nothing.
package bps_pkg;

	localparam int MAX_WIDTH = 64;
	localparam int LEN_W     = 7;
	localparam int CTZ_W     = $clog2(MAX_WIDTH);

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(32);

	typedef logic [MAX_WIDTH-1:0] word_t;
	typedef logic [LEN_W-1:0]     len_t;

	typedef struct packed {
		word_t word;
		logic  found;
	} bps_result_t;

	// Ones in the low bits that form the sequence; clamp length to 1..MAX_WIDTH.
	function automatic word_t bps_mask(input len_t len);
		len_t  l;
		word_t m;
		l = len;
		if (l == '0) begin
			l = LEN_W'(1);
		end
		if (l > LEN_W'(MAX_WIDTH)) begin
			l = LEN_W'(MAX_WIDTH);
		end
		for (int i = 0; i < MAX_WIDTH; i++) begin
			m[i] = (LEN_W'(i) < l);
		end
		return m;
	endfunction

endpackage

### rtl/bps_next.sv
// Next larger word with the same number of one bits inside the window.
// Uses bps_pkg.
module bps_next (
	input  bps_pkg::word_t x,
	input  bps_pkg::word_t mask,
	output bps_pkg::word_t res,
	output logic           ok
);
	import bps_pkg::*;

	word_t            low;
	word_t            r;
	word_t            tail;
	logic             carry;
	logic [CTZ_W-1:0] tz;

	assign low          = x & (~x + word_t'(1));
	assign {carry, r}   = {1'b0, x} + {1'b0, low};

	// encode the isolated lowest set bit
	always_comb begin
		tz = '0;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			if (low[i]) begin
				tz = tz | CTZ_W'(i);
			end
		end
	end

	assign tail = ((x ^ r) >> 2) >> tz;
	assign ok   = (x != '0) && !carry && ((r & ~mask) == '0);
	assign res  = (r | tail) & mask;

endmodule

### rtl/bps_step.sv
// Direction handling around the next-permutation core: previous is the
// complement of next taken on the complemented window. Uses bps_pkg, bps_next.
module bps_step (
	input  logic                kind,
	input  bps_pkg::word_t      x,
	input  bps_pkg::word_t      mask,
	output bps_pkg::bps_result_t result
);
	import bps_pkg::*;

	word_t core_in;
	word_t core_res;
	word_t perm;
	logic  core_ok;

	assign core_in = kind ? (~x & mask) : x;

	bps_next u_next (
		.x    (core_in),
		.mask (mask),
		.res  (core_res),
		.ok   (core_ok)
	);

	assign perm         = kind ? (~core_res & mask) : core_res;
	assign result.word  = core_ok ? perm : x;
	assign result.found = core_ok;

endmodule

### rtl/bit_permutation_step_top.sv
// Top level of the bit permutation step block: config register, input stage,
// permutation logic and output register. Uses bps_pkg and bps_step.
// Each input is held in the input stage, and its result in the output register.
// Throughput: one item per cycle while out_stall is low; the input stage still
// takes a new transfer while a result waits on a stalled output, if it is empty.
// Reset: clears both valid flags and sets word_length to 32.
module bit_permutation_step_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                word_length_we,
	input  bps_pkg::len_t       word_length_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  bps_pkg::word_t      word_in,
	output logic                out_valid,
	input  logic                out_stall,
	output bps_pkg::word_t      word_out,
	output logic                found
);
	import bps_pkg::*;

	word_t       mask_q;
	logic        valid_s1;
	logic        kind_s1;
	word_t       x_s1;
	logic        out_valid_q;
	bps_result_t res_q;
	bps_result_t res;
	logic        out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= bps_mask(LEN_RESET);
		end else if (word_length_we) begin
			mask_q <= bps_mask(word_length_wdata);
		end
	end

	assign out_load = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			x_s1    <= word_in & mask_q;
		end
	end

	bps_step u_step (
		.kind   (kind_s1),
		.x      (x_s1),
		.mask   (mask_q),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && valid_s1) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign word_out  = res_q.word;
	assign found     = res_q.found;

	a_count_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res.found |-> $countones(res.word) == $countones(x_s1))
		else $error("permutation changed the number of one bits");

	a_next_larger: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res.found && !kind_s1 |-> res.word > x_s1)
		else $error("next permutation not larger");

	a_prev_smaller: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res.found && kind_s1 |-> res.word < x_s1)
		else $error("previous permutation not smaller");

	a_none_unchanged: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !res.found |-> res.word == x_s1)
		else $error("word changed without a permutation");

	a_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (res.word & ~mask_q) == '0)
		else $error("result has bits outside the window");

endmodule
